[design/bounded_priority_ready_queue_defines.svh]
// Assertion macros for the bounded priority ready queue checker.
// No dependencies; included by the checker file only.
`ifndef BOUNDED_PRIORITY_READY_QUEUE_DEFINES_SVH
`define BOUNDED_PRIORITY_READY_QUEUE_DEFINES_SVH

// Property checked on every rising clock edge while out of reset.
`define BRPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define BRPQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[design/brpq_pkg.sv]
// Shared types and constants of the bounded priority ready queue.
// No dependencies; used by the interfaces, the cell and the top level.
package brpq_pkg;

    // Default queue depth.
    localparam int QUEUE_DEPTH_DEF = 16;

    // Field widths.
    localparam int ID_W   = 16;
    localparam int PRI_W  = 8;
    localparam int TIME_W = 16;
    localparam int OCC_W  = 5;

    // Input actions.
    localparam logic ACT_CREATE = 1'b0;
    localparam logic ACT_SWAP   = 1'b1;

    // One queued process.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRI_W-1:0]  pri;
        logic [TIME_W-1:0] tm;
    } t_entry;

    // What a cell shows to its neighbours.
    typedef struct packed {
        logic   valid;
        logic   ge;
        t_entry entry;
    } t_cell_view;

    // Operation broadcast to every cell.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP,
        CELL_POP_INSERT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_entry   entry;
    } t_cell_ctl;

    // Input transaction payload.
    typedef struct packed {
        logic              action;
        logic [PRI_W-1:0]  new_priority;
        logic [TIME_W-1:0] new_time;
        logic              ret_valid;
        logic [ID_W-1:0]   ret_id;
        logic [PRI_W-1:0]  ret_priority;
        logic [TIME_W-1:0] ret_time;
    } t_in_item;

    // Result transaction payload.
    typedef struct packed {
        logic              out_valid;
        logic [ID_W-1:0]   out_id;
        logic [PRI_W-1:0]  out_priority;
        logic [TIME_W-1:0] out_time;
        logic [OCC_W-1:0]  occupancy;
        logic              is_full;
    } t_out_item;

endpackage

[design/brpq_if.sv]
// Valid/ready channel interfaces for the queue's input and result streams.
// Depends on brpq_pkg for the payload types.
interface brpq_in_if;
    import brpq_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface brpq_out_if;
    import brpq_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[design/brpq_cell.sv]
// One slot of the shift-register priority queue.
// Depends on brpq_pkg; instantiated in a row by the top level.
module brpq_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_first,
    input  brpq_pkg::t_cell_ctl   i_ctl,
    input  brpq_pkg::t_cell_view  i_prev,
    input  brpq_pkg::t_cell_view  i_next,
    output brpq_pkg::t_cell_view  o_view
);
    import brpq_pkg::*;

    logic   r_valid;
    logic   n_valid;
    t_entry r_entry;
    t_entry n_entry;
    logic   ge_self;

    // This slot holds an entry that stays ahead of the incoming one.
    assign ge_self = r_valid && (r_entry.pri >= i_ctl.entry.pri);

    assign o_view.valid = r_valid;
    assign o_view.ge    = ge_self;
    assign o_view.entry = r_entry;

    // Choose between keeping, loading the new entry, or shifting a neighbour in.
    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        unique case (i_ctl.op)
            CELL_HOLD: begin
            end
            CELL_INSERT: begin
                if (ge_self) begin
                end else if (i_prev.ge) begin
                    n_valid = 1'b1;
                    n_entry = i_ctl.entry;
                end else begin
                    n_valid = i_prev.valid;
                    n_entry = i_prev.entry;
                end
            end
            CELL_POP: begin
                n_valid = i_next.valid;
                n_entry = i_next.entry;
            end
            CELL_POP_INSERT: begin
                // The head leaves; the new entry lands behind all that stay ahead.
                if (i_next.ge) begin
                    n_valid = i_next.valid;
                    n_entry = i_next.entry;
                end else if (ge_self || i_first) begin
                    n_valid = 1'b1;
                    n_entry = i_ctl.entry;
                end
            end
            default: begin
            end
        endcase
    end

    // Valid bit is control state; the entry itself needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

[design/bounded_priority_ready_queue.sv]
// Bounded priority ready queue: a row of QUEUE_DEPTH cells kept in descending priority,
// first in first out among equal priorities. Every cell compares its own priority with
// the incoming one and takes its next value from itself, a neighbour or the new entry,
// so a create, a pop or a pop with re-insert updates all cells at once: one transaction
// is accepted per cycle while input ready is high, that is while the output register is
// empty or being taken in the same cycle; the result appears there on the next cycle.
// A write of i_cfg_data reloads the next id to be given out. Depends on brpq_pkg and brpq_if.
module bounded_priority_ready_queue #(
    parameter int QUEUE_DEPTH = brpq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    brpq_in_if.sink                  i_in,
    brpq_out_if.source               o_out,
    input  logic                     i_cfg_we,
    input  logic [brpq_pkg::ID_W-1:0] i_cfg_data
);
    import brpq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic             r_out_valid;
    t_out_item        r_out;
    t_out_item        n_out;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [ID_W-1:0]  r_next_id;
    logic [ID_W-1:0]  n_next_id;
    t_cell_ctl        cell_ctl;
    t_cell_view       views [QUEUE_DEPTH];
    t_cell_view       prev_views [QUEUE_DEPTH];
    t_cell_view       next_views [QUEUE_DEPTH];
    logic             accept;
    logic             full;
    logic             ret_live;
    t_in_item         item;

    assign item     = i_in.payload;
    assign accept   = i_in.valid && i_in.ready;
    assign full     = (r_count == CNT_W'(QUEUE_DEPTH));
    assign ret_live = item.ret_valid && (item.ret_time != '0);

    assign i_in.ready    = !r_out_valid || o_out.ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    // Decode the transaction into a cell operation, the new count and the result.
    always_comb begin
        cell_ctl.op    = CELL_HOLD;
        cell_ctl.entry = '{id: r_next_id, pri: item.new_priority, tm: item.new_time};
        n_count        = r_count;
        n_next_id      = r_next_id;
        n_out          = '0;
        if (accept) begin
            if (item.action == ACT_CREATE) begin
                if (!full) begin
                    cell_ctl.op = CELL_INSERT;
                    n_count     = r_count + CNT_W'(1);
                    n_next_id   = r_next_id + ID_W'(1);
                end
            end else if (views[0].valid) begin
                // Dispatch the head, then put the returned process back if it is live.
                n_out.out_valid    = 1'b1;
                n_out.out_id       = views[0].entry.id;
                n_out.out_priority = views[0].entry.pri;
                n_out.out_time     = views[0].entry.tm;
                cell_ctl.entry     = '{id: item.ret_id, pri: item.ret_priority,
                                       tm: item.ret_time};
                if (ret_live) begin
                    cell_ctl.op = CELL_POP_INSERT;
                end else begin
                    cell_ctl.op = CELL_POP;
                    n_count     = r_count - CNT_W'(1);
                end
            end else if (ret_live) begin
                // Empty queue: the returned process runs on directly.
                n_out.out_valid    = 1'b1;
                n_out.out_id       = item.ret_id;
                n_out.out_priority = item.ret_priority;
                n_out.out_time     = item.ret_time;
            end
        end
        n_out.occupancy = OCC_W'(n_count);
        n_out.is_full   = (n_count == CNT_W'(QUEUE_DEPTH));
    end

    // Neighbour wiring; the ends see an empty slot, the head sees an open front.
    always_comb begin
        prev_views[0]             = '0;
        prev_views[0].ge          = 1'b1;
        next_views[QUEUE_DEPTH-1] = '0;
        for (int k = 1; k < QUEUE_DEPTH; k++) begin
            prev_views[k]   = views[k-1];
            next_views[k-1] = views[k];
        end
    end

    // The row of queue cells.
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        brpq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_first (g == 0),
            .i_ctl   (cell_ctl),
            .i_prev  (prev_views[g]),
            .i_next  (next_views[g]),
            .o_view  (views[g])
        );
    end

    // Count, next id and result handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_next_id   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cfg_we) begin
                r_next_id <= i_cfg_data;
            end else begin
                r_next_id <= n_next_id;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload is loaded with each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule

[design/brpq_checker.sv]
// Port-level assertions for the bounded priority ready queue, bound to its top level.
// Depends on brpq_pkg and the assertion macros in the defines header.
`include "bounded_priority_ready_queue_defines.svh"

module brpq_port_assertions (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input brpq_pkg::t_out_item         i_out_payload
);
    import brpq_pkg::*;

    // A waiting result stays offered and unchanged.
    `BRPQ_ASSERT(a_out_hold, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_payload)), "Stalled result transaction changed or vanished")

    // With no result pending, the queue takes a new transaction.
    `BRPQ_ASSERT(a_ready_when_empty, !i_out_valid |-> i_in_ready, "Input not ready while output register is empty")

    // An accepted transaction always produces a result on the next cycle.
    `BRPQ_ASSERT(a_result_follows, (i_in_valid && i_in_ready) |=> i_out_valid, "Accepted transaction gave no result")

    // Nothing dispatched means the process fields are zero.
    `BRPQ_ASSERT_ALWAYS(a_idle_zero, (i_out_valid && !i_out_payload.out_valid) |-> (i_out_payload.out_id == '0 && i_out_payload.out_priority == '0 && i_out_payload.out_time == '0), "Non-zero process fields without dispatch")

endmodule

bind bounded_priority_ready_queue brpq_port_assertions u_brpq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload)
);
